// ===== rtl/hkft_pkg.sv =====
// ----------------------------------------------------------------------------
// hkft_pkg: shared types and constants
// Sizes of the table, the bucket count register and the front-to-back request.
// ----------------------------------------------------------------------------
package hkft_pkg;
    localparam int BUCKETS    = 256;
    localparam int WAYS       = 4;
    localparam int BKT_W      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CFG_W      = 9;
    localparam int KEY_W      = 32;
    localparam int CNT_W      = 32;
    localparam int SLOT_W     = KEY_W + CNT_W + 1;
    localparam int QDEPTH     = 2;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [BKT_W-1:0] bucket;
    } req_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_WAIT,
        BK_CHECK,
        BK_SCAN,
        BK_CLEAR
    } bk_state_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_DIV,
        FR_PUSH
    } fr_state_t;
endpackage

// ===== rtl/hashed_key_frequency_table.sv =====
// Push to result: a bit-serial modulo, the queue hand-off, then a read and
// check of each way in turn; a hit updates the count, a miss after the last
// way inserts the key or flags the bucket full. The front takes a new key
// once the last is queued; the back end works on the previous key meanwhile
// and starts the next once its result is popped. Reset sets the bucket count
// to 256 and clears all 1024 slots in a pass; keys wait queued until it ends.
// ----------------------------------------------------------------------------
// hashed_key_frequency_table: set-associative key frequency counter
// Counts accesses per key in a hashed table with a fixed number of ways.
// ----------------------------------------------------------------------------
module hashed_key_frequency_table
    import hkft_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             push,
    output logic             full,
    input  logic [KEY_W-1:0] dest_key,
    output logic             empty,
    input  logic             pop,
    output logic [CNT_W-1:0] access_count,
    output logic             was_hit,
    output logic             bucket_full,
    output logic [7:0]       bucket_index
);
    logic [CFG_W-1:0] bcount_reg;
    logic             qp, qf, qe, qpop;
    req_t             qin, qout;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcount_reg <= CFG_W'(BUCKETS);
        end
        else if (cfg_we)
        begin
            bcount_reg <= cfg_wdata;
        end
    end

    hkft_front u_front (
        .clk(clk), .rst_n(rst_n), .bucket_count(bcount_reg),
        .in_push(push), .in_key(dest_key), .in_full(full),
        .q_push(qp), .q_data(qin), .q_full(qf)
    );

    hkft_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(qp), .wdata(qin), .full(qf),
        .pop(qpop), .rdata(qout), .empty(qe)
    );

    hkft_back u_back (
        .clk(clk), .rst_n(rst_n), .q_empty(qe), .q_data(qout), .q_pop(qpop),
        .empty(empty), .pop(pop), .access_count(access_count),
        .was_hit(was_hit), .bucket_full(bucket_full), .bucket_index(bucket_index)
    );
endmodule

// ===== rtl/hkft_ram.sv =====
// ----------------------------------------------------------------------------
// hkft_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module hkft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== rtl/hkft_front.sv =====
// ----------------------------------------------------------------------------
// hkft_front: key intake and bucket selection
// Takes a key, reduces it modulo the bucket count (clamped to 1..256) one bit a cycle and hands
// the request to the queue.
// ----------------------------------------------------------------------------
module hkft_front
    import hkft_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CFG_W-1:0] bucket_count,
    input  logic             in_push,
    input  logic [KEY_W-1:0] in_key,
    output logic             in_full,
    output logic             q_push,
    output req_t             q_data,
    input  logic             q_full
);
    fr_state_t          state_reg, state_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [KEY_W-1:0]   sh_reg, sh_next;
    logic [CFG_W:0]     rem_reg, rem_next;
    logic [CFG_W-1:0]   div_reg, div_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [CFG_W:0]     trial;
    logic [CFG_W-1:0]   eff;

    always_comb
    begin
        eff = bucket_count;
        if (bucket_count == '0)
        begin
            eff = CFG_W'(1);
        end
        if (32'(bucket_count) > 32'(BUCKETS))
        begin
            eff = CFG_W'(BUCKETS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        cnt_reg <= cnt_next;
    end

    always_comb
    begin
        state_next = state_reg;
        key_next   = key_reg;
        sh_next    = sh_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        cnt_next   = cnt_reg;
        in_full    = 1'b1;
        q_push     = 1'b0;
        trial      = {rem_reg[CFG_W-1:0], sh_reg[KEY_W-1]};
        q_data.key    = key_reg;
        q_data.bucket = BKT_W'(rem_reg);
        unique case (state_reg)
            FR_IDLE:
            begin
                in_full = 1'b0;
                if (in_push)
                begin
                    key_next   = in_key;
                    sh_next    = in_key;
                    rem_next   = '0;
                    div_next   = eff;
                    cnt_next   = '0;
                    state_next = FR_DIV;
                end
            end
            FR_DIV:
            begin
                // Restoring division, one quotient bit per cycle.
                if (trial >= {1'b0, div_reg})
                begin
                    rem_next = trial - {1'b0, div_reg};
                end
                else
                begin
                    rem_next = trial;
                end
                sh_next  = {sh_reg[KEY_W-2:0], 1'b0};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(KEY_W - 1))
                begin
                    state_next = FR_PUSH;
                end
            end
            FR_PUSH:
            begin
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    state_next = FR_IDLE;
                end
            end
            default:
            begin
                state_next = FR_IDLE;
            end
        endcase
    end
endmodule

// ===== rtl/hkft_queue.sv =====
// ----------------------------------------------------------------------------
// hkft_queue: request queue between front and back
// A small FIFO in flip-flops.
// ----------------------------------------------------------------------------
module hkft_queue
    import hkft_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  req_t wdata,
    output logic full,
    input  logic pop,
    output req_t rdata,
    output logic empty
);
    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    req_t          slot_reg [QDEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [PW:0]   cnt_reg;

    assign full  = (cnt_reg == (PW+1)'(QDEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = slot_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wp_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wp_reg <= (wp_reg == PW'(QDEPTH - 1)) ? '0 : wp_reg + PW'(1);
            end
            if (pop && !empty)
            begin
                rp_reg <= (rp_reg == PW'(QDEPTH - 1)) ? '0 : rp_reg + PW'(1);
            end
            cnt_reg <= cnt_reg + (PW+1)'(push && !full) - (PW+1)'(pop && !empty);
        end
    end
endmodule

// ===== rtl/hkft_back.sv =====
// ----------------------------------------------------------------------------
// hkft_back: bucket lookup and update
// Clears the table after reset, then reads the ways of the bucket one at a
// time, updates the count, inserts the key or flags a full bucket, and leaves
// the result in an output register.
// ----------------------------------------------------------------------------
module hkft_back
    import hkft_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  req_t             q_data,
    output logic             q_pop,
    output logic             empty,
    input  logic             pop,
    output logic [CNT_W-1:0] access_count,
    output logic             was_hit,
    output logic             bucket_full,
    output logic [7:0]       bucket_index
);
    localparam int ENTRIES = BUCKETS * WAYS;
    localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    bk_state_t          state_reg, state_next;
    req_t               req_reg, req_next;
    logic [WAY_W-1:0]   way_reg, way_next;
    logic               free_reg, free_next;
    logic [WAY_W-1:0]   fway_reg, fway_next;
    logic [ADDR_W-1:0]  clr_reg, clr_next;
    logic               ovalid_reg;
    logic [CNT_W-1:0]   ocnt_reg;
    logic               ohit_reg, ofull_reg;
    logic [7:0]         obkt_reg;

    logic               we;
    logic [ADDR_W-1:0]  addr;
    logic [SLOT_W-1:0]  wdata, rdata;
    logic               done;
    logic [CNT_W-1:0]   dcnt;
    logic               dhit, dfull;
    logic [ADDR_W-1:0]  cur;
    logic [CNT_W-1:0]   rcnt;
    logic               rvalid;

    // Each slot holds the valid bit, the key and the count.
    hkft_ram #(.WIDTH(SLOT_W), .DEPTH(ENTRIES)) u_ram (
        .clk   (clk),
        .we    (we),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    assign empty        = !ovalid_reg;
    assign access_count = ocnt_reg;
    assign was_hit      = ohit_reg;
    assign bucket_full  = ofull_reg;
    assign bucket_index = obkt_reg;
    assign cur          = ADDR_W'(32'(req_reg.bucket) * WAYS + 32'(way_reg));
    assign rcnt         = rdata[CNT_W-1:0];
    assign rvalid       = rdata[SLOT_W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BK_CLEAR;
            clr_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (done)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (pop)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        way_reg  <= way_next;
        free_reg <= free_next;
        fway_reg <= fway_next;
        if (done)
        begin
            ocnt_reg  <= dcnt;
            ohit_reg  <= dhit;
            ofull_reg <= dfull;
            obkt_reg  <= 8'(req_reg.bucket);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        way_next   = way_reg;
        free_next  = free_reg;
        fway_next  = fway_reg;
        clr_next   = clr_reg;
        q_pop      = 1'b0;
        we         = 1'b0;
        addr       = cur;
        wdata      = {1'b1, req_reg.key, CNT_W'(1)};
        done       = 1'b0;
        dcnt       = '0;
        dhit       = 1'b0;
        dfull      = 1'b0;
        unique case (state_reg)
            BK_CLEAR:
            begin
                // One slot per cycle is written invalid after reset.
                we       = 1'b1;
                addr     = clr_reg;
                wdata    = '0;
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(ENTRIES - 1))
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                // Start only when the output register is free to take a result.
                if (!q_empty && !ovalid_reg)
                begin
                    q_pop      = 1'b1;
                    req_next   = q_data;
                    way_next   = '0;
                    free_next  = 1'b0;
                    state_next = BK_READ;
                end
            end
            BK_READ:
            begin
                state_next = BK_WAIT;
            end
            BK_WAIT:
            begin
                state_next = BK_CHECK;
            end
            BK_CHECK:
            begin
                if (rvalid && rdata[SLOT_W-2:CNT_W] == req_reg.key)
                begin
                    dcnt  = (rcnt == '1) ? rcnt : rcnt + CNT_W'(1);
                    dhit  = 1'b1;
                    we    = 1'b1;
                    wdata = {1'b1, req_reg.key, dcnt};
                    done  = 1'b1;
                    state_next = BK_IDLE;
                end
                else
                begin
                    if (!rvalid && !free_reg)
                    begin
                        free_next = 1'b1;
                        fway_next = way_reg;
                    end
                    if (32'(way_reg) == WAYS - 1)
                    begin
                        state_next = BK_SCAN;
                    end
                    else
                    begin
                        way_next   = way_reg + WAY_W'(1);
                        state_next = BK_WAIT;
                    end
                end
            end
            BK_SCAN:
            begin
                addr = ADDR_W'(32'(req_reg.bucket) * WAYS + 32'(fway_reg));
                done = 1'b1;
                if (free_reg)
                begin
                    we   = 1'b1;
                    dcnt = CNT_W'(1);
                end
                else
                begin
                    dfull = 1'b1;
                end
                state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end
endmodule

// ===== rtl/hkft_checker.sv =====
// ----------------------------------------------------------------------------
// hkft_checker: port-level checks
// Watches the result side of the table.
// ----------------------------------------------------------------------------
module hkft_checker
    import hkft_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             empty,
    input logic             pop,
    input logic [CNT_W-1:0] access_count,
    input logic             was_hit,
    input logic             bucket_full
);
    // A waiting result stays until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(access_count)))
        else $error("result changed while waiting");
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && bucket_full) |-> (!was_hit && access_count == '0))
        else $error("overflow result inconsistent");
    a_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !was_hit && !bucket_full) |-> (access_count == CNT_W'(1)))
        else $error("new key count not one");
    a_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && was_hit) |-> (access_count >= CNT_W'(2)))
        else $error("hit count below two");
endmodule

bind hashed_key_frequency_table hkft_checker u_checker (
    .clk(clk), .rst_n(rst_n), .empty(empty), .pop(pop),
    .access_count(access_count), .was_hit(was_hit), .bucket_full(bucket_full)
);
